@@ design/pft_pkg.sv @@
// Shared types and codes for the printf format tokenizer.
// No dependencies; imported by the tokenizer and its port checker.
`timescale 1ns / 1ps
`default_nettype none
package pft_pkg;

  localparam int POS_W     = 12;
  localparam int LEN_W     = 13;
  localparam int NUM_W     = 17;
  localparam int MAX_WIDTH = 65535;

  typedef enum logic [1:0] {
    TK_LITERAL = 2'd0,
    TK_CONV    = 2'd1,
    TK_END     = 2'd2
  } token_kind_t;

  typedef enum logic [2:0] {
    CV_CHAR   = 3'd0,
    CV_SINT   = 3'd1,
    CV_UINT   = 3'd2,
    CV_POS    = 3'd3,
    CV_PTR    = 3'd4,
    CV_STR    = 3'd5,
    CV_SZSTR  = 3'd6
  } conv_kind_t;

  typedef enum logic [1:0] {
    SZ_SHORT = 2'd1,
    SZ_NONE  = 2'd2,
    SZ_LONG  = 2'd3
  } size_code_t;

  typedef enum logic [2:0] {
    PH_TEXT,
    PH_FLAGS,
    PH_WIDTH,
    PH_DOT,
    PH_PREC,
    PH_LONG,
    PH_SPEC
  } phase_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [POS_W-1:0]        start;
    logic [LEN_W-1:0]        len;
    logic [5:0]              flags;
    logic signed [NUM_W-1:0] wval;
    logic signed [NUM_W-1:0] pval;
    logic [1:0]              size;
    logic [2:0]              conv;
    logic [4:0]              base;
    logic                    last;
  } token_t;

endpackage
`default_nettype wire

@@ design/printf_format_tokenizer.sv @@
// printf format tokenizer: one format character in, literal, conversion and end tokens out.
// Depends on pft_pkg.
//
// The block takes one character per clock while in_ready is high and updates its scan
// state in the same cycle; the tokens a character produces go into a four-entry output
// queue that drives the out_ ports. Most characters produce no token or one. A NUL that
// closes a pending literal produces two (the literal, then the end token). in_ready is
// high while at least two queue entries are free, so with out_ready held high the
// sustained rate is one character per cycle; a token is registered into the queue and
// reaches the outputs once the entries ahead of it are taken. After the end token the
// position restarts at zero for the next string; positions wrap modulo 4096.
`timescale 1ns / 1ps
`default_nettype none
module printf_format_tokenizer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [7:0]                       in_char_in,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [1:0]                       out_token_kind,
  output      logic [pft_pkg::POS_W-1:0]        out_start_pos,
  output      logic [pft_pkg::LEN_W-1:0]        out_token_len,
  output      logic [5:0]                       out_flag_bits,
  output      logic signed [pft_pkg::NUM_W-1:0] out_width_value,
  output      logic signed [pft_pkg::NUM_W-1:0] out_precision_value,
  output      logic [1:0]                       out_size_code,
  output      logic [2:0]                       out_conversion_kind,
  output      logic [4:0]                       out_number_base,
  output      logic                             out_last_of_run
);
  import pft_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_US    = 8'h53;

  localparam logic signed [NUM_W-1:0] NUM_DEFAULT = -17'sd1;
  localparam logic signed [NUM_W-1:0] NUM_FROM_ARG = -17'sd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  function automatic logic signed [NUM_W-1:0] acc_digit(input logic [NUM_W-2:0] a,
                                                        input logic [3:0] d);
    logic [NUM_W+2:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{(NUM_W-1){1'b0}}, d};
    if (v > (NUM_W+3)'(MAX_WIDTH)) begin
      return NUM_W'(MAX_WIDTH);
    end
    return {1'b0, v[NUM_W-2:0]};
  endfunction

  phase_t                  phase_r, phase_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        start_r, start_nxt;
  logic                    pend_r, pend_nxt;
  logic [5:0]              flags_r, flags_nxt;
  logic signed [NUM_W-1:0] wacc_r, wacc_nxt;
  logic signed [NUM_W-1:0] pacc_r, pacc_nxt;
  logic [1:0]              size_r, size_nxt;

  token_t                  queue_r [QDEPTH];
  logic [QPTR_W-1:0]       wp_r, rp_r;
  logic [QPTR_W:0]         cnt_r, cnt_nxt;

  token_t                  t0, t1;
  logic [1:0]              n_tok;
  logic                    in_acc, out_acc;
  logic [7:0]              c;
  logic                    is_dig, is_flag;
  logic                    do_ws, do_aw, do_len, do_spec;
  logic                    spec_known;
  logic [2:0]              spec_conv;
  logic [4:0]              spec_base;
  logic [LEN_W-1:0]        span;
  token_t                  end_tok;

  assign c       = in_char_in;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready  = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);

  assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_flag = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_SPACE) ||
                   (c == CH_HASH) || (c == CH_ZERO);
  assign span    = {1'b0, pos_r - start_r};

  assign do_ws  = (phase_r == PH_FLAGS) && !is_flag;
  assign do_aw  = (do_ws && !is_dig && (c != CH_STAR)) ||
                  ((phase_r == PH_WIDTH) && !(!wacc_r[NUM_W-1] && is_dig));
  assign do_len = (do_aw && (c != CH_DOT)) ||
                  ((phase_r == PH_DOT) && !is_dig && (c != CH_STAR)) ||
                  ((phase_r == PH_PREC) && !(!pacc_r[NUM_W-1] && is_dig));
  assign do_spec = (do_len && (c != CH_H) && (c != CH_L) && (c != CH_UL)) ||
                   ((phase_r == PH_LONG) && (c != CH_L)) ||
                   (phase_r == PH_SPEC);

  always_comb begin
    spec_known = 1'b1;
    spec_conv  = CV_CHAR;
    spec_base  = 5'd0;
    case (c) inside
      CH_C: begin
        spec_conv = CV_CHAR;
      end
      CH_D, CH_I: begin
        spec_conv = CV_SINT;
        spec_base = 5'd10;
      end
      CH_U: begin
        spec_conv = CV_UINT;
        spec_base = 5'd10;
      end
      CH_O: begin
        spec_conv = CV_UINT;
        spec_base = 5'd8;
      end
      CH_N: begin
        spec_conv = CV_POS;
      end
      CH_UX, CH_X: begin
        spec_conv = CV_UINT;
        spec_base = 5'd16;
      end
      CH_P: begin
        spec_conv = CV_PTR;
        spec_base = 5'd16;
      end
      CH_S: begin
        spec_conv = CV_STR;
      end
      CH_US: begin
        spec_conv = CV_SZSTR;
      end
      default: begin
        spec_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    end_tok       = '0;
    end_tok.kind  = TK_END;
    end_tok.start = pos_r;
    end_tok.size  = SZ_NONE;

    phase_nxt = phase_r;
    pos_nxt   = pos_r + POS_W'(1);
    start_nxt = start_r;
    pend_nxt  = pend_r;
    flags_nxt = flags_r;
    wacc_nxt  = wacc_r;
    pacc_nxt  = pacc_r;
    size_nxt  = size_r;
    n_tok     = 2'd0;
    t0        = '0;
    t1        = '0;

    if (phase_r == PH_TEXT) begin
      if ((c == CH_NUL) || (c == CH_PCT)) begin
        if (pend_r) begin
          t0.kind  = TK_LITERAL;
          t0.start = start_r;
          t0.len   = span;
          t0.size  = SZ_NONE;
          n_tok    = 2'd1;
        end
        pend_nxt = 1'b0;
        if (c == CH_NUL) begin
          if (pend_r) begin
            t1    = end_tok;
            n_tok = 2'd2;
          end else begin
            t0    = end_tok;
            n_tok = 2'd1;
          end
        end else begin
          start_nxt = pos_r;
          flags_nxt = '0;
          wacc_nxt  = NUM_DEFAULT;
          pacc_nxt  = NUM_DEFAULT;
          size_nxt  = SZ_NONE;
          phase_nxt = PH_FLAGS;
        end
      end else if (!pend_r) begin
        pend_nxt  = 1'b1;
        start_nxt = pos_r;
      end
    end else if (phase_r == PH_FLAGS && is_flag) begin
      case (c)
        CH_MINUS: flags_nxt = flags_r | 6'h01;
        CH_PLUS:  flags_nxt = flags_r | 6'h02;
        CH_SPACE: flags_nxt = flags_r | 6'h04;
        CH_HASH:  flags_nxt = flags_r | 6'h08;
        default:  flags_nxt = flags_r | 6'h10;
      endcase
    end else if (do_ws && (is_dig || (c == CH_STAR))) begin
      wacc_nxt  = is_dig ? {{(NUM_W-4){1'b0}}, c[3:0]} : NUM_FROM_ARG;
      phase_nxt = PH_WIDTH;
    end else if (phase_r == PH_WIDTH && !do_aw) begin
      wacc_nxt = acc_digit(wacc_r[NUM_W-2:0], c[3:0]);
    end else if (do_aw && (c == CH_DOT)) begin
      phase_nxt = PH_DOT;
    end else if (phase_r == PH_DOT && !do_len) begin
      pacc_nxt  = is_dig ? {{(NUM_W-4){1'b0}}, c[3:0]} : NUM_FROM_ARG;
      phase_nxt = PH_PREC;
    end else if (phase_r == PH_PREC && !do_len) begin
      pacc_nxt = acc_digit(pacc_r[NUM_W-2:0], c[3:0]);
    end else if (do_len && !do_spec) begin
      if (c == CH_H) begin
        size_nxt  = SZ_SHORT;
        phase_nxt = PH_SPEC;
      end else if (c == CH_L) begin
        size_nxt  = SZ_LONG;
        phase_nxt = PH_LONG;
      end else begin
        size_nxt  = SZ_NONE;
        phase_nxt = PH_SPEC;
      end
    end else if (phase_r == PH_LONG && !do_spec) begin
      phase_nxt = PH_SPEC;
    end else if (do_spec) begin
      if (c == CH_NUL) begin
        t0    = end_tok;
        n_tok = 2'd1;
      end else if (spec_known) begin
        if (c == CH_UX) begin
          flags_nxt = flags_r | 6'h20;
        end
        t0.kind  = TK_CONV;
        t0.start = start_r;
        t0.len   = span + LEN_W'(1);
        t0.flags = (c == CH_UX) ? (flags_r | 6'h20) : flags_r;
        t0.wval  = wacc_r;
        t0.pval  = pacc_r;
        t0.size  = size_r;
        t0.conv  = spec_conv;
        t0.base  = spec_base;
        n_tok    = 2'd1;
        phase_nxt = PH_TEXT;
      end else begin
        pend_nxt  = 1'b1;
        start_nxt = pos_r;
        phase_nxt = PH_TEXT;
      end
    end

    if (n_tok == 2'd1) begin
      t0.last = 1'b1;
    end
    if (n_tok == 2'd2) begin
      t1.last = 1'b1;
    end

    if (c == CH_NUL) begin
      phase_nxt = PH_TEXT;
      pos_nxt   = '0;
      start_nxt = '0;
      pend_nxt  = 1'b0;
      flags_nxt = '0;
      wacc_nxt  = NUM_DEFAULT;
      pacc_nxt  = NUM_DEFAULT;
      size_nxt  = SZ_NONE;
    end

    cnt_nxt = cnt_r + (in_acc ? (QPTR_W+1)'(n_tok) : '0) - (QPTR_W+1)'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      pos_r   <= '0;
      start_r <= '0;
      pend_r  <= 1'b0;
      flags_r <= '0;
      wacc_r  <= NUM_DEFAULT;
      pacc_r  <= NUM_DEFAULT;
      size_r  <= SZ_NONE;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
      flags_r <= flags_nxt;
      wacc_r  <= wacc_nxt;
      pacc_r  <= pacc_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        wp_r <= wp_r + QPTR_W'(n_tok);
      end
      if (out_acc) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (n_tok != 2'd0)) begin
      queue_r[wp_r] <= t0;
    end
    if (in_acc && (n_tok == 2'd2)) begin
      queue_r[wp_r + QPTR_W'(1)] <= t1;
    end
  end

  assign out_token_kind      = queue_r[rp_r].kind;
  assign out_start_pos       = queue_r[rp_r].start;
  assign out_token_len       = queue_r[rp_r].len;
  assign out_flag_bits       = queue_r[rp_r].flags;
  assign out_width_value     = queue_r[rp_r].wval;
  assign out_precision_value = queue_r[rp_r].pval;
  assign out_size_code       = queue_r[rp_r].size;
  assign out_conversion_kind = queue_r[rp_r].conv;
  assign out_number_base     = queue_r[rp_r].base;
  assign out_last_of_run     = queue_r[rp_r].last;

endmodule
`default_nettype wire

@@ design/pft_port_checker.sv @@
// Port-level checks for the printf format tokenizer, bound to the top level.
// Depends on pft_pkg and printf_format_tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module pft_port_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [1:0]                       out_token_kind,
  input wire logic [pft_pkg::POS_W-1:0]        out_start_pos,
  input wire logic [pft_pkg::LEN_W-1:0]        out_token_len,
  input wire logic [5:0]                       out_flag_bits,
  input wire logic [1:0]                       out_size_code,
  input wire logic                             out_last_of_run
);
  import pft_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
      $stable(out_start_pos) && $stable(out_token_len))
    else $error("stalled output item changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_kind == TK_LITERAL) || (out_token_kind == TK_CONV) ||
      (out_token_kind == TK_END))
    else $error("illegal token kind");

  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == TK_CONV) |-> (out_token_len != '0))
    else $error("conversion item with zero length");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == TK_END) |-> out_last_of_run && (out_token_len == '0))
    else $error("end item not last of run or nonzero length");

  a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != TK_CONV) |->
      (out_flag_bits == '0) && (out_size_code == SZ_NONE))
    else $error("literal or end item carries conversion fields");

endmodule

bind printf_format_tokenizer pft_port_checker u_pft_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_start_pos   (out_start_pos),
  .out_token_len   (out_token_len),
  .out_flag_bits   (out_flag_bits),
  .out_size_code   (out_size_code),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire
